// ===== rtl/ppg_pkg.sv =====
`default_nettype none

package ppg_pkg;

  // Fixed field widths
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned REG_W   = 5;
  localparam int unsigned INDEX_W = 5;
  localparam int unsigned USE_W   = 6;   // permutation use counters wrap at 64

  // Default program shape
  localparam int unsigned NUM_REGS_DEF  = 32;
  localparam int unsigned CACHE_OPS_DEF = 11;
  localparam int unsigned MATH_OPS_DEF  = 18;
  localparam int unsigned DAG_LOADS_DEF = 4;

  // Shared divider: quotient bits retired per cycle
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_ITERS = WORD_W / DIV_BITS;

  // Seed hash and KISS99 constants
  localparam logic [WORD_W-1:0] FNV_BASIS  = 32'h811C_9DC5;
  localparam logic [WORD_W-1:0] FNV_PRIME  = 32'h0100_0193;
  localparam logic [WORD_W-1:0] KISS_Z_MUL = 32'd36969;
  localparam logic [WORD_W-1:0] KISS_W_MUL = 32'd18000;
  localparam logic [WORD_W-1:0] KISS_C_MUL = 32'd69069;
  localparam logic [WORD_W-1:0] KISS_C_ADD = 32'd1234567;

  typedef enum logic [1:0] {
    OP_CACHE = 2'd0,
    OP_MATH  = 2'd1,
    OP_DAG   = 2'd2
  } op_kind_e;

endpackage

`default_nettype wire

// ===== rtl/progpow_program_generator_core.sv =====
// One period is worked on at a time.
// Throughput is set by the shared 32-bit multiplier (used for each KISS99 draw) and the
//   shared divider (used for each modulo). A waiting result does not stall generation
//   until the next result is ready. Reset clears the sequencer and the output valid.
`default_nettype none

module progpow_program_generator_core #(
  parameter int unsigned NUM_REGS  = ppg_pkg::NUM_REGS_DEF,
  parameter int unsigned CACHE_OPS = ppg_pkg::CACHE_OPS_DEF,
  parameter int unsigned MATH_OPS  = ppg_pkg::MATH_OPS_DEF,
  parameter int unsigned DAG_LOADS = ppg_pkg::DAG_LOADS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [63:0]                       period_number_i,
  // output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [1:0]                        op_kind_o,
  output logic      [ppg_pkg::INDEX_W-1:0]       op_index_o,
  output logic      [ppg_pkg::REG_W-1:0]         source_a_o,
  output logic      [ppg_pkg::REG_W-1:0]         source_b_o,
  output logic      [ppg_pkg::REG_W-1:0]         dest_reg_o,
  output logic      [ppg_pkg::WORD_W-1:0]        select_a_o,
  output logic      [ppg_pkg::WORD_W-1:0]        select_b_o,
  output logic                                   last_op_o
);

  localparam int unsigned RW    = $clog2(NUM_REGS);
  localparam int unsigned NW    = $clog2(NUM_REGS + 1);
  localparam int unsigned MOD   = NUM_REGS * (NUM_REGS - 1);
  localparam int unsigned DW    = $clog2(MOD + 1);
  localparam int unsigned STEPS = (CACHE_OPS > MATH_OPS) ? CACHE_OPS : MATH_OPS;
  localparam int unsigned SW    = $clog2(STEPS + 1);
  localparam int unsigned GW    = $clog2(DAG_LOADS + 1);
  localparam int unsigned WW    = ppg_pkg::WORD_W;
  localparam int unsigned UW    = ppg_pkg::USE_W;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SEED,
    S_INIT,
    S_DRAW,
    S_SH_DIV,
    S_SH_WAIT,
    S_SW_RD,
    S_SW_W1,
    S_SW_W2,
    S_OP_TOP,
    S_C_RD,
    S_C_SEL,
    S_M_DIV1,
    S_M_WAIT1,
    S_M_DIV2,
    S_M_WAIT2,
    S_M_SEL1,
    S_M_SEL2,
    S_G_TOP,
    S_G_SEL
  } state_e;

  state_e state_q, ret_q;

  // Sequencer state
  logic [1:0]    dstep_q;
  logic [1:0]    seed_cnt_q;
  logic [63:0]   period_q;
  logic [RW-1:0] init_k_q;
  logic [NW-1:0] n_q;
  logic          ph_src_q;
  logic [RW-1:0] j_q;
  logic [SW-1:0] i_q;
  logic          m_q;
  logic [GW-1:0] g_q;
  logic [DW-1:0] r_q;
  logic [RW-1:0] s1_q, s2_q;

  // KISS99 state
  logic [WW-1:0] z_q, w_q, jsr_q, jcong_q, mwc_q, rnd_q, sela_q;

  // Permutation use counters: raw 6-bit count and its residue modulo NUM_REGS
  logic [RW-1:0] didx_q, sidx_q, didx_nx, sidx_nx;
  logic [UW-1:0] dcnt_q, scnt_q;

  // Output register
  logic                      out_valid_q;
  ppg_pkg::op_kind_e         kind_q;
  logic [ppg_pkg::INDEX_W-1:0] index_q;
  logic [ppg_pkg::REG_W-1:0] src_a_q, src_b_q, dst_q;
  logic [WW-1:0]             sel_a_q, sel_b_q;
  logic                      last_q;

  // ---------------------------------------------------------------------------
  // Shared multiplier: FNV mixes during seeding, KISS99 MWC and congruential
  // updates during draws.
  // ---------------------------------------------------------------------------
  logic [WW-1:0] mul_x, mul_y, mul_c, mul_p, seed_h, seed_d;

  always_comb begin
    case (seed_cnt_q)
      2'd0:    seed_h = ppg_pkg::FNV_BASIS;
      2'd1:    seed_h = z_q;
      2'd2:    seed_h = w_q;
      default: seed_h = jsr_q;
    endcase
    seed_d = seed_cnt_q[0] ? period_q[63:32] : period_q[31:0];
  end

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    mul_c = '0;
    case (state_q)
      S_SEED: begin
        mul_x = seed_h ^ seed_d;
        mul_y = ppg_pkg::FNV_PRIME;
      end
      S_DRAW: begin
        case (dstep_q)
          2'd0: begin
            mul_x = {16'd0, z_q[15:0]};
            mul_y = ppg_pkg::KISS_Z_MUL;
            mul_c = {16'd0, z_q[31:16]};
          end
          2'd1: begin
            mul_x = {16'd0, w_q[15:0]};
            mul_y = ppg_pkg::KISS_W_MUL;
            mul_c = {16'd0, w_q[31:16]};
          end
          2'd2: begin
            mul_x = jcong_q;
            mul_y = ppg_pkg::KISS_C_MUL;
            mul_c = ppg_pkg::KISS_C_ADD;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign mul_p = mul_x * mul_y + mul_c;

  // xorshift step of the KISS99 shift register
  logic [WW-1:0] jsr_x1, jsr_x2, jsr_nx;
  assign jsr_x1 = jsr_q ^ (jsr_q << 17);
  assign jsr_x2 = jsr_x1 ^ (jsr_x1 >> 13);
  assign jsr_nx = jsr_x2 ^ (jsr_x2 << 5);

  // ---------------------------------------------------------------------------
  // Shared divider: shuffle bound, math source pair, and its split by NUM_REGS.
  // ---------------------------------------------------------------------------
  logic          div_start, div_done;
  logic [WW-1:0] div_dividend, div_quot;
  logic [DW-1:0] div_divisor, div_rem;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = rnd_q;
    div_divisor  = DW'(n_q);
    case (state_q)
      S_SH_DIV: div_start = 1'b1;
      S_M_DIV1: begin
        div_start   = 1'b1;
        div_divisor = DW'(MOD);
      end
      S_M_DIV2: begin
        div_start    = 1'b1;
        div_dividend = WW'(r_q);
        div_divisor  = DW'(NUM_REGS);
      end
      default: ;
    endcase
  end

  ppg_div #(
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Second math source skips over the first one
  logic [RW-1:0] src_t, src_s1, src_s2;
  assign src_t  = div_quot[RW-1:0];
  assign src_s1 = div_rem[RW-1:0];
  assign src_s2 = (src_t >= src_s1) ? RW'(src_t + 1'b1) : src_t;

  // ---------------------------------------------------------------------------
  // Permutation stores
  // ---------------------------------------------------------------------------
  logic [RW-1:0] nm1;
  logic [RW-1:0] pw_addr, pw_data;
  logic          d_we, s_we, d_re, s_re;
  logic [RW-1:0] d_raddr, s_raddr;
  logic [RW-1:0] d_rd_a, d_rd_b, s_rd_a, s_rd_b;

  assign nm1 = RW'(n_q - NW'(1));

  always_comb begin
    pw_addr = init_k_q;
    pw_data = init_k_q;
    d_we    = 1'b0;
    s_we    = 1'b0;
    case (state_q)
      S_INIT: begin
        d_we = 1'b1;
        s_we = 1'b1;
      end
      S_SW_W1: begin
        pw_addr = nm1;
        pw_data = ph_src_q ? s_rd_b : d_rd_b;
        d_we    = !ph_src_q;
        s_we    = ph_src_q;
      end
      S_SW_W2: begin
        pw_addr = j_q;
        pw_data = ph_src_q ? s_rd_a : d_rd_a;
        d_we    = !ph_src_q;
        s_we    = ph_src_q;
      end
      default: ;
    endcase
  end

  assign d_raddr = (state_q == S_SW_RD) ? nm1 : didx_q;
  assign s_raddr = (state_q == S_SW_RD) ? nm1 : sidx_q;
  assign d_re    = ((state_q == S_SW_RD) && !ph_src_q) || (state_q == S_C_RD) ||
                   (state_q == S_M_SEL1) || (state_q == S_G_TOP);
  assign s_re    = ((state_q == S_SW_RD) && ph_src_q) || (state_q == S_C_RD);

  ppg_perm #(
    .NUM_REGS(NUM_REGS)
  ) u_dest_perm (
    .clk_i     (clk_i),
    .we_i      (d_we),
    .waddr_i   (pw_addr),
    .wdata_i   (pw_data),
    .re_i      (d_re),
    .raddr_a_i (d_raddr),
    .raddr_b_i (j_q),
    .rdata_a_o (d_rd_a),
    .rdata_b_o (d_rd_b)
  );

  ppg_perm #(
    .NUM_REGS(NUM_REGS)
  ) u_src_perm (
    .clk_i     (clk_i),
    .we_i      (s_we),
    .waddr_i   (pw_addr),
    .wdata_i   (pw_data),
    .re_i      (s_re),
    .raddr_a_i (s_raddr),
    .raddr_b_i (j_q),
    .rdata_a_o (s_rd_a),
    .rdata_b_o (s_rd_b)
  );

  // Residue tracks the 6-bit count modulo NUM_REGS, including its wrap at 64
  assign didx_nx = ((dcnt_q == '1) || (didx_q == RW'(NUM_REGS - 1))) ? '0 : didx_q + 1'b1;
  assign sidx_nx = ((scnt_q == '1) || (sidx_q == RW'(NUM_REGS - 1))) ? '0 : sidx_q + 1'b1;

  // Output slot is free when empty or being drained this cycle
  logic slot_free;
  assign slot_free = !out_valid_q || out_ready_i;

  // A result state loads the output register whenever the slot is free
  logic out_load;
  assign out_load = slot_free &&
                    ((state_q == S_C_SEL) || (state_q == S_M_SEL2) || (state_q == S_G_SEL));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      dstep_q     <= '0;
      seed_cnt_q  <= '0;
      period_q    <= '0;
      init_k_q    <= '0;
      n_q         <= '0;
      ph_src_q    <= 1'b0;
      j_q         <= '0;
      i_q         <= '0;
      m_q         <= 1'b0;
      g_q         <= '0;
      r_q         <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      z_q         <= '0;
      w_q         <= '0;
      jsr_q       <= '0;
      jcong_q     <= '0;
      mwc_q       <= '0;
      rnd_q       <= '0;
      sela_q      <= '0;
      didx_q      <= '0;
      sidx_q      <= '0;
      dcnt_q      <= '0;
      scnt_q      <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= ppg_pkg::OP_CACHE;
      index_q     <= '0;
      src_a_q     <= '0;
      src_b_q     <= '0;
      dst_q       <= '0;
      sel_a_q     <= '0;
      sel_b_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      // load a new result, or drop the current one once transferred
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            period_q   <= period_number_i;
            seed_cnt_q <= '0;
            state_q    <= S_SEED;
          end
        end

        // chain four FNV-1a mixes into z, w, jsr, jcong
        S_SEED: begin
          seed_cnt_q <= seed_cnt_q + 1'b1;
          case (seed_cnt_q)
            2'd0: z_q   <= mul_p;
            2'd1: w_q   <= mul_p;
            2'd2: jsr_q <= mul_p;
            default: begin
              jcong_q  <= mul_p;
              init_k_q <= '0;
              state_q  <= S_INIT;
            end
          endcase
        end

        // write identity into both permutations, one entry a cycle
        S_INIT: begin
          if (init_k_q == RW'(NUM_REGS - 1)) begin
            n_q      <= NW'(NUM_REGS);
            ph_src_q <= 1'b0;
            didx_q   <= '0;
            sidx_q   <= '0;
            dcnt_q   <= '0;
            scnt_q   <= '0;
            i_q      <= '0;
            m_q      <= 1'b0;
            g_q      <= '0;
            dstep_q  <= '0;
            ret_q    <= S_SH_DIV;
            state_q  <= S_DRAW;
          end else begin
            init_k_q <= init_k_q + 1'b1;
          end
        end

        // one KISS99 draw: z, then w, then jcong, jsr and mwc, then the result; then return to the caller
        S_DRAW: begin
          dstep_q <= dstep_q + 1'b1;
          case (dstep_q)
            2'd0: z_q <= mul_p;
            2'd1: w_q <= mul_p;
            2'd2: begin
              jcong_q <= mul_p;
              jsr_q   <= jsr_nx;
              mwc_q   <= (z_q << 16) + w_q;
            end
            default: begin
              rnd_q   <= (mwc_q ^ jcong_q) + jsr_q;
              state_q <= ret_q;
            end
          endcase
        end

        // Fisher-Yates: j = draw mod n, swap entries n-1 and j
        S_SH_DIV:  state_q <= S_SH_WAIT;
        S_SH_WAIT: begin
          if (div_done) begin
            j_q     <= div_rem[RW-1:0];
            state_q <= S_SW_RD;
          end
        end
        S_SW_RD: state_q <= S_SW_W1;
        S_SW_W1: state_q <= S_SW_W2;
        S_SW_W2: begin
          if (!ph_src_q) begin
            ph_src_q <= 1'b1;
            ret_q    <= S_SH_DIV;
            state_q  <= S_DRAW;
          end else begin
            ph_src_q <= 1'b0;
            if (n_q == NW'(2)) begin
              state_q <= S_OP_TOP;
            end else begin
              n_q     <= n_q - NW'(1);
              ret_q   <= S_SH_DIV;
              state_q <= S_DRAW;
            end
          end
        end

        // step i: cache op first, then math op
        S_OP_TOP: begin
          if (i_q == SW'(STEPS)) begin
            state_q <= S_G_TOP;
          end else if (!m_q) begin
            if (i_q < SW'(CACHE_OPS)) begin
              state_q <= S_C_RD;
            end else begin
              m_q <= 1'b1;
            end
          end else begin
            if (i_q < SW'(MATH_OPS)) begin
              ret_q   <= S_M_DIV1;
              state_q <= S_DRAW;
            end else begin
              m_q <= 1'b0;
              i_q <= i_q + 1'b1;
            end
          end
        end

        S_C_RD: begin
          sidx_q  <= sidx_nx;
          scnt_q  <= scnt_q + 1'b1;
          didx_q  <= didx_nx;
          dcnt_q  <= dcnt_q + 1'b1;
          ret_q   <= S_C_SEL;
          state_q <= S_DRAW;
        end
        S_C_SEL: begin
          if (slot_free) begin
            kind_q      <= ppg_pkg::OP_CACHE;
            index_q     <= ppg_pkg::INDEX_W'(i_q);
            src_a_q     <= ppg_pkg::REG_W'(s_rd_a);
            src_b_q     <= '0;
            dst_q       <= ppg_pkg::REG_W'(d_rd_a);
            sel_a_q     <= rnd_q;
            sel_b_q     <= '0;
            last_q      <= 1'b0;
            m_q         <= 1'b1;
            state_q     <= S_OP_TOP;
          end
        end

        // math sources: r = draw mod N(N-1), then split r by N
        S_M_DIV1:  state_q <= S_M_WAIT1;
        S_M_WAIT1: begin
          if (div_done) begin
            r_q     <= div_rem;
            state_q <= S_M_DIV2;
          end
        end
        S_M_DIV2:  state_q <= S_M_WAIT2;
        S_M_WAIT2: begin
          if (div_done) begin
            s1_q    <= src_s1;
            s2_q    <= src_s2;
            ret_q   <= S_M_SEL1;
            state_q <= S_DRAW;
          end
        end
        S_M_SEL1: begin
          sela_q  <= rnd_q;
          didx_q  <= didx_nx;
          dcnt_q  <= dcnt_q + 1'b1;
          ret_q   <= S_M_SEL2;
          state_q <= S_DRAW;
        end
        S_M_SEL2: begin
          if (slot_free) begin
            kind_q      <= ppg_pkg::OP_MATH;
            index_q     <= ppg_pkg::INDEX_W'(i_q);
            src_a_q     <= ppg_pkg::REG_W'(s1_q);
            src_b_q     <= ppg_pkg::REG_W'(s2_q);
            dst_q       <= ppg_pkg::REG_W'(d_rd_a);
            sel_a_q     <= sela_q;
            sel_b_q     <= rnd_q;
            last_q      <= 1'b0;
            m_q         <= 1'b0;
            i_q         <= i_q + 1'b1;
            state_q     <= S_OP_TOP;
          end
        end

        // DAG merges: the first one always targets register 0
        S_G_TOP: begin
          if (g_q != '0) begin
            didx_q <= didx_nx;
            dcnt_q <= dcnt_q + 1'b1;
          end
          ret_q   <= S_G_SEL;
          state_q <= S_DRAW;
        end
        S_G_SEL: begin
          if (slot_free) begin
            kind_q      <= ppg_pkg::OP_DAG;
            index_q     <= ppg_pkg::INDEX_W'(g_q);
            src_a_q     <= '0;
            src_b_q     <= '0;
            dst_q       <= (g_q == '0) ? '0 : ppg_pkg::REG_W'(d_rd_a);
            sel_a_q     <= rnd_q;
            sel_b_q     <= '0;
            last_q      <= (g_q == GW'(DAG_LOADS - 1));
            if (g_q == GW'(DAG_LOADS - 1)) begin
              state_q <= S_IDLE;
            end else begin
              g_q     <= g_q + 1'b1;
              state_q <= S_G_TOP;
            end
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign op_kind_o   = kind_q;
  assign op_index_o  = index_q;
  assign source_a_o  = src_a_q;
  assign source_b_o  = src_b_q;
  assign dest_reg_o  = dst_q;
  assign select_a_o  = sel_a_q;
  assign select_b_o  = sel_b_q;
  assign last_op_o   = last_q;

endmodule

`default_nettype wire

// ===== rtl/ppg_div.sv =====
`default_nettype none

// Iterative restoring divider, DIV_BITS quotient bits per cycle.
module ppg_div #(
  parameter int unsigned DW = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [ppg_pkg::WORD_W-1:0]    dividend_i,
  input  wire logic [DW-1:0]                 divisor_i,
  output logic                               done_o,
  output logic      [ppg_pkg::WORD_W-1:0]    quot_o,
  output logic      [DW-1:0]                 rem_o
);

  localparam int unsigned CW = (ppg_pkg::DIV_ITERS > 1) ? $clog2(ppg_pkg::DIV_ITERS) : 1;

  logic [ppg_pkg::WORD_W-1:0] acc_q, acc_d;
  logic [DW-1:0]              rem_q, rem_d;
  logic [DW-1:0]              div_q;
  logic [CW-1:0]              cnt_q;
  logic                       run_q;
  logic                       done_q;

  always_comb begin
    logic [DW:0] trial;
    rem_d = rem_q;
    acc_d = acc_q;
    for (int k = 0; k < int'(ppg_pkg::DIV_BITS); k++) begin
      trial = {rem_d, acc_d[ppg_pkg::WORD_W-1]};
      acc_d = {acc_d[ppg_pkg::WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial    = trial - {1'b0, div_q};
        acc_d[0] = 1'b1;
      end
      rem_d = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && run_q && (cnt_q == CW'(ppg_pkg::DIV_ITERS - 1));
      if (start_i) begin
        acc_q <= dividend_i;
        rem_q <= '0;
        div_q <= divisor_i;
        cnt_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        acc_q <= acc_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(ppg_pkg::DIV_ITERS - 1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/ppg_perm.sv =====
`default_nettype none

// Register permutation store: one write port, two registered read ports.
module ppg_perm #(
  parameter int unsigned NUM_REGS = ppg_pkg::NUM_REGS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [$clog2(NUM_REGS)-1:0]  waddr_i,
  input  wire logic [$clog2(NUM_REGS)-1:0]  wdata_i,
  input  wire logic                         re_i,
  input  wire logic [$clog2(NUM_REGS)-1:0]  raddr_a_i,
  input  wire logic [$clog2(NUM_REGS)-1:0]  raddr_b_i,
  output logic      [$clog2(NUM_REGS)-1:0]  rdata_a_o,
  output logic      [$clog2(NUM_REGS)-1:0]  rdata_b_o
);

  localparam int unsigned RW = $clog2(NUM_REGS);

  logic [RW-1:0] mem_q [NUM_REGS];
  logic [RW-1:0] rd_a_q;
  logic [RW-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_a_q <= mem_q[raddr_a_i];
      rd_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

`default_nettype wire

// ===== verif/progpow_program_checker.sv =====
`timescale 1ns / 100ps

module progpow_program_checker #(
  parameter int unsigned NUM_REGS  = ppg_pkg::NUM_REGS_DEF,
  parameter int unsigned CACHE_OPS = ppg_pkg::CACHE_OPS_DEF,
  parameter int unsigned MATH_OPS  = ppg_pkg::MATH_OPS_DEF,
  parameter int unsigned DAG_LOADS = ppg_pkg::DAG_LOADS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [63:0]                   period_number_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [1:0]                    op_kind_i,
  input  logic [ppg_pkg::INDEX_W-1:0]   op_index_i,
  input  logic [ppg_pkg::REG_W-1:0]     source_a_i,
  input  logic [ppg_pkg::REG_W-1:0]     source_b_i,
  input  logic [ppg_pkg::REG_W-1:0]     dest_reg_i,
  input  logic [ppg_pkg::WORD_W-1:0]    select_a_i,
  input  logic [ppg_pkg::WORD_W-1:0]    select_b_i,
  input  logic                          last_op_i,
  output int                            mismatch_count_o,
  output int                            pending_ops_o
);

  localparam int unsigned PAIR_SPAN  = NUM_REGS * (NUM_REGS - 1);
  localparam int unsigned STEP_COUNT = (CACHE_OPS > MATH_OPS) ? CACHE_OPS : MATH_OPS;
  localparam int unsigned PRINT_CAP  = 100;

  typedef struct packed {
    ppg_pkg::op_kind_e               kind;
    logic [ppg_pkg::INDEX_W-1:0]     index;
    logic [ppg_pkg::REG_W-1:0]       src_a;
    logic [ppg_pkg::REG_W-1:0]       src_b;
    logic [ppg_pkg::REG_W-1:0]       dest;
    logic [ppg_pkg::WORD_W-1:0]      sel_a;
    logic [ppg_pkg::WORD_W-1:0]      sel_b;
    logic                            last;
  } program_op_t;

  program_op_t program_q[$];
  int          mismatches = 0;

  // KISS99 words and register orders of the period being expanded
  logic [31:0]              kiss_z, kiss_w, kiss_jsr, kiss_jcong;
  logic [ppg_pkg::REG_W-1:0] dest_order [NUM_REGS];
  logic [ppg_pkg::REG_W-1:0] src_order  [NUM_REGS];
  int unsigned              dest_uses, src_uses;

  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [31:0] d);
    return (h ^ d) * ppg_pkg::FNV_PRIME;
  endfunction

  function automatic logic [31:0] kiss_next();
    logic [31:0] mwc;
    kiss_z     = ppg_pkg::KISS_Z_MUL * {16'd0, kiss_z[15:0]} + {16'd0, kiss_z[31:16]};
    kiss_w     = ppg_pkg::KISS_W_MUL * {16'd0, kiss_w[15:0]} + {16'd0, kiss_w[31:16]};
    mwc        = (kiss_z << 16) + kiss_w;
    kiss_jsr   = kiss_jsr ^ (kiss_jsr << 17);
    kiss_jsr   = kiss_jsr ^ (kiss_jsr >> 13);
    kiss_jsr   = kiss_jsr ^ (kiss_jsr << 5);
    kiss_jcong = ppg_pkg::KISS_C_MUL * kiss_jcong + ppg_pkg::KISS_C_ADD;
    return (mwc ^ kiss_jcong) + kiss_jsr;
  endfunction

  function automatic logic [ppg_pkg::REG_W-1:0] next_dest();
    logic [ppg_pkg::REG_W-1:0] r;
    r         = dest_order[dest_uses % NUM_REGS];
    dest_uses = (dest_uses + 1) & 63;
    return r;
  endfunction

  function automatic logic [ppg_pkg::REG_W-1:0] take_src();
    logic [ppg_pkg::REG_W-1:0] r;
    r        = src_order[src_uses % NUM_REGS];
    src_uses = (src_uses + 1) & 63;
    return r;
  endfunction

  // Expand one period into its program and queue every operation in output order.
  function automatic void expand_period(input logic [63:0] period);
    int unsigned               i;
    int unsigned               j;
    logic [31:0]               pick;
    logic [31:0]               s1, s2;
    logic [ppg_pkg::REG_W-1:0] swap;
    program_op_t               op;
    kiss_z     = fnv_mix(ppg_pkg::FNV_BASIS, period[31:0]);
    kiss_w     = fnv_mix(kiss_z, period[63:32]);
    kiss_jsr   = fnv_mix(kiss_w, period[31:0]);
    kiss_jcong = fnv_mix(kiss_jsr, period[63:32]);
    for (i = 0; i < NUM_REGS; i++) begin
      dest_order[i] = ppg_pkg::REG_W'(i);
      src_order[i]  = ppg_pkg::REG_W'(i);
    end
    // Top-down shuffle, destination and source swaps interleaved
    for (i = NUM_REGS; i > 1; i--) begin
      j               = kiss_next() % i;
      swap            = dest_order[i-1];
      dest_order[i-1] = dest_order[j];
      dest_order[j]   = swap;
      j               = kiss_next() % i;
      swap            = src_order[i-1];
      src_order[i-1]  = src_order[j];
      src_order[j]    = swap;
    end
    dest_uses = 0;
    src_uses  = 0;
    for (i = 0; i < STEP_COUNT; i++) begin
      if (i < CACHE_OPS) begin
        op.kind  = ppg_pkg::OP_CACHE;
        op.index = ppg_pkg::INDEX_W'(i);
        op.src_a = take_src();
        op.src_b = '0;
        op.dest  = next_dest();
        op.sel_a = kiss_next();
        op.sel_b = '0;
        op.last  = 1'b0;
        program_q.push_back(op);
      end
      if (i < MATH_OPS) begin
        pick = kiss_next() % PAIR_SPAN;
        s1   = pick % NUM_REGS;
        s2   = pick / NUM_REGS;
        if (s2 >= s1) s2 = s2 + 1;
        op.kind  = ppg_pkg::OP_MATH;
        op.index = ppg_pkg::INDEX_W'(i);
        op.src_a = s1[ppg_pkg::REG_W-1:0];
        op.src_b = s2[ppg_pkg::REG_W-1:0];
        op.sel_a = kiss_next();
        op.dest  = next_dest();
        op.sel_b = kiss_next();
        op.last  = 1'b0;
        program_q.push_back(op);
      end
    end
    // The first merge always lands on register 0
    for (i = 0; i < DAG_LOADS; i++) begin
      op.kind  = ppg_pkg::OP_DAG;
      op.index = ppg_pkg::INDEX_W'(i);
      op.src_a = '0;
      op.src_b = '0;
      op.dest  = (i == 0) ? '0 : next_dest();
      op.sel_a = kiss_next();
      op.sel_b = '0;
      op.last  = (i + 1 == DAG_LOADS);
      program_q.push_back(op);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    // Keep the log short; count every mismatch anyway
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input program_op_t ref_op);
    if (got !== want)
      report_mismatch($sformatf("kind %0d op %0d %s got 0x%0h want 0x%0h",
                                ref_op.kind, ref_op.index, name, got, want));
  endtask

  always @(posedge clk_i) begin
    program_op_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) expand_period(period_number_i);
      if (out_valid_i && out_ready_i) begin
        if (program_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer kind %0d op %0d",
                                    op_kind_i, op_index_i));
        end else begin
          want = program_q.pop_front();
          check_field("op_kind", op_kind_i, want.kind, want);
          check_field("op_index", op_index_i, want.index, want);
          check_field("source_a", source_a_i, want.src_a, want);
          check_field("source_b", source_b_i, want.src_b, want);
          check_field("dest_reg", dest_reg_i, want.dest, want);
          check_field("select_a", select_a_i, want.sel_a, want);
          check_field("select_b", select_b_i, want.sel_b, want);
          check_field("last_op", last_op_i, want.last, want);
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_ops_o    <= program_q.size();
  end

endmodule

// ===== verif/tb_progpow_program_generator_core.sv =====
`timescale 1ns / 100ps

module tb_progpow_program_generator_core;

  localparam int unsigned RANDOM_PERIODS = 370;
  // Cycle limit for the whole run, beyond which the watchdog ends it
  localparam int unsigned CYCLE_LIMIT    = 4_000_000;
  // Quiet time after the last expected transfer: longer than one full period
  localparam int unsigned DRAIN_CYCLES   = 2500;
  // Long receiver hold-off: several periods' worth, so the input backs up
  localparam int unsigned HOLD_CYCLES    = 6000;
  localparam int unsigned CORNER_COUNT   = 14;

  logic                            clk             = 1'b0;
  logic                            rst_n           = 1'b0;
  logic                            in_valid        = 1'b0;
  logic [63:0]                     period_number   = '0;
  logic                            out_ready       = 1'b0;
  logic                            in_ready;
  logic                            out_valid;
  logic [1:0]                      op_kind;
  logic [ppg_pkg::INDEX_W-1:0]     op_index;
  logic [ppg_pkg::REG_W-1:0]       source_a;
  logic [ppg_pkg::REG_W-1:0]       source_b;
  logic [ppg_pkg::REG_W-1:0]       dest_reg;
  logic [ppg_pkg::WORD_W-1:0]      select_a;
  logic [ppg_pkg::WORD_W-1:0]      select_b;
  logic                            last_op;

  int          mismatch_count;
  int          pending_ops;
  int unsigned periods_sent = 0;
  int unsigned cycle_count  = 0;
  int unsigned tx_idle_max  = 6;
  int unsigned rx_idle_max  = 6;
  logic        rx_hold      = 1'b0;

  // Corner periods: extremes of both words, walking bit patterns, and low words
  // that zero the KISS99 z (and then w) seed so the degenerate generator paths run.
  logic [63:0] corner_periods [CORNER_COUNT] = '{
    64'h0000_0000_0000_0000,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_0000_FFFF_FFFF,
    64'hFFFF_FFFF_0000_0000,
    64'h0000_0000_0000_0001,
    64'h8000_0000_0000_0000,
    64'h0000_0001_0000_0000,
    64'h7FFF_FFFF_FFFF_FFFF,
    64'h5555_5555_5555_5555,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h0000_0000_811C_9DC5,
    64'hFFFF_FFFF_811C_9DC5,
    64'h0000_0000_0000_02A5,
    64'h0123_4567_89AB_CDEF
  };

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  progpow_program_generator_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .period_number_i (period_number),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .op_kind_o       (op_kind),
    .op_index_o      (op_index),
    .source_a_o      (source_a),
    .source_b_o      (source_b),
    .dest_reg_o      (dest_reg),
    .select_a_o      (select_a),
    .select_b_o      (select_b),
    .last_op_o       (last_op)
  );

  progpow_program_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .period_number_i  (period_number),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .op_kind_i        (op_kind),
    .op_index_i       (op_index),
    .source_a_i       (source_a),
    .source_b_i       (source_b),
    .dest_reg_i       (dest_reg),
    .select_a_i       (select_a),
    .select_b_i       (select_b),
    .last_op_i        (last_op),
    .mismatch_count_o (mismatch_count),
    .pending_ops_o    (pending_ops)
  );

  // Offer one period and hold it until the input transfer happens. Drop valid only
  // for a nonzero gap, so a back-to-back offer never lowers and raises valid in the
  // same step.
  task automatic send_period(input logic [63:0] period);
    int unsigned gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    period_number <= period;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    periods_sent <= periods_sent + 1;
  endtask

  // Stop offering and wait until every queued operation has come out.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_ops != 0) @(posedge clk);
  endtask

  // Stimulus: reset, corner periods, then random periods
  initial begin : stimulus
    int unsigned n;
    logic [63:0] period;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < CORNER_COUNT; n++) send_period(corner_periods[n]);

    for (n = 0; n < RANDOM_PERIODS; n++) begin
      // Switch between bursts with no gaps and bursts with random gaps
      if (n % 40 == 0) tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      // Pause once mid-run until the block has fully drained
      if (n == 150) wait_for_drain();
      case ($urandom_range(0, 7))
        0:       period = {32'd0, 32'($urandom_range(0, 4000))};  // realistic small periods
        1:       period = 64'd1 << $urandom_range(0, 63);         // single set bit
        default: period = {$urandom, $urandom};
      endcase
      send_period(period);
    end
    in_valid <= 1'b0;

    // Wait for the last program, then watch for stray transfers
    @(posedge clk);
    while (pending_ops != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: random gap per transfer; a hold-off seen between transfers keeps ready low until it ends.
  // Keep ready high across back-to-back transfers instead of toggling it.
  initial begin : receiver
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 64 == 0) rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      gap = $urandom_range(0, rx_idle_max);
      if (gap != 0 || rx_hold) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Long hold-off: start it once the random part is under way, count it here
  initial begin : receiver_hold
    while (periods_sent < CORNER_COUNT + 60) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// ===== files.f =====
rtl/ppg_pkg.sv
rtl/ppg_div.sv
rtl/ppg_perm.sv
rtl/progpow_program_generator_core.sv
verif/progpow_program_checker.sv
verif/tb_progpow_program_generator_core.sv
